// ===== rtl/core/fp32_add_operand_align_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the operand alignment block
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef FP32_ADD_OPERAND_ALIGN_MACROS_SVH
`define FP32_ADD_OPERAND_ALIGN_MACROS_SVH

// same-cycle implication
`define FPALIGN_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FPALIGN_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/fpalign_pkg.sv =====
// ---------------------------------------------------------------------------
// fpalign_pkg
// Types, constants and helpers shared by the fp32 operand alignment block.
// ---------------------------------------------------------------------------
`default_nettype none

package fpalign_pkg;

	localparam int unsigned OPND_W  = 32;
	localparam int unsigned EXP_W   = 8;
	localparam int unsigned MANT_W  = 23;
	localparam int unsigned FRAC_W  = 28;
	localparam int unsigned SHIFT_W = 5;   // enough bits to index the 28-bit fraction

	// working-format field values
	localparam logic [1:0] INT_NORMAL   = 2'b01;
	localparam logic [1:0] INT_DENORMAL = 2'b00;
	localparam logic [2:0] GUARD_ZERO   = 3'b000;

	typedef logic [OPND_W-1:0] opnd_t;
	typedef logic [EXP_W-1:0]  exp_t;
	typedef logic [FRAC_W-1:0] frac_t;

	// unpacked operand pair, ready for the alignment shift
	typedef struct packed {
		logic  a_big;       // a has the strictly larger exponent
		exp_t  larger_exp;
		exp_t  shift_dist;  // shift distance for the smaller operand
		frac_t big_frac;
		frac_t small_frac;
	} unpack_t;

	function automatic exp_t get_exp(input opnd_t op);
		return op[MANT_W +: EXP_W];
	endfunction

	// integer bits, fraction bits, guard bits
	function automatic frac_t widen_fraction(input opnd_t op, input logic denormal);
		return {(denormal ? INT_DENORMAL : INT_NORMAL), op[MANT_W-1:0], GUARD_ZERO};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fpalign_if.sv =====
// ---------------------------------------------------------------------------
// fpalign channel interfaces
// Valid/ready channels for operand pairs and aligned results.
// ---------------------------------------------------------------------------
`default_nettype none

interface fpalign_in_if;
	logic                 valid;
	logic                 ready;
	fpalign_pkg::opnd_t   operand_a;
	fpalign_pkg::opnd_t   operand_b;

	modport source (output valid, output operand_a, output operand_b, input ready);
	modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface fpalign_out_if;
	logic                 valid;
	logic                 ready;
	fpalign_pkg::exp_t    larger_exponent;
	fpalign_pkg::frac_t   aligned_fraction_a;
	fpalign_pkg::frac_t   aligned_fraction_b;

	modport source (output valid, output larger_exponent, output aligned_fraction_a,
		output aligned_fraction_b, input ready);
	modport sink   (input valid, input larger_exponent, input aligned_fraction_a,
		input aligned_fraction_b, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fpalign_unpack.sv =====
// ---------------------------------------------------------------------------
// fpalign_unpack
// Exponent compare, denormal detect, fraction widening and shift distance.
// ---------------------------------------------------------------------------
`default_nettype none

module fpalign_unpack (
	input  fpalign_pkg::opnd_t    operand_a,
	input  fpalign_pkg::opnd_t    operand_b,
	output fpalign_pkg::unpack_t  unp
);
	import fpalign_pkg::*;

	exp_t  exp_a, exp_b, diff;
	logic  dn_a, dn_b, a_big, one_dn;
	frac_t frac_a, frac_b;

	// exponents and denormal flags
	always_comb begin
		exp_a  = get_exp(operand_a);
		exp_b  = get_exp(operand_b);
		dn_a   = (exp_a == '0);
		dn_b   = (exp_b == '0);
		a_big  = (exp_a > exp_b);
		one_dn = (dn_a != dn_b);
		frac_a = widen_fraction(operand_a, dn_a);
		frac_b = widen_fraction(operand_b, dn_b);
	end

	// difference; a denormal counts as exponent one
	always_comb begin
		diff = a_big ? (exp_a - exp_b) : (exp_b - exp_a);
		unp.a_big      = a_big;
		unp.larger_exp = a_big ? exp_a : exp_b;
		unp.shift_dist = diff - {{(EXP_W-1){1'b0}}, one_dn};
		unp.big_frac   = a_big ? frac_a : frac_b;
		unp.small_frac = a_big ? frac_b : frac_a;
	end

endmodule

`default_nettype wire

// ===== rtl/core/fpalign_shift.sv =====
// ---------------------------------------------------------------------------
// fpalign_shift
// Right shift of the smaller fraction with sticky collection into bit 0.
// ---------------------------------------------------------------------------
`default_nettype none

module fpalign_shift (
	input  fpalign_pkg::frac_t  small_frac,
	input  fpalign_pkg::exp_t   shift_dist,
	output fpalign_pkg::frac_t  aligned
);
	import fpalign_pkg::*;

	logic                long_shift;
	logic [SHIFT_W-1:0]  amt;
	frac_t               shifted, lost_mask;
	logic                sticky;

	// barrel shift; anything at or past the width shifts every bit out into the sticky bit
	always_comb begin
		long_shift = (shift_dist >= EXP_W'(FRAC_W));
		amt        = shift_dist[SHIFT_W-1:0];
		shifted    = long_shift ? '0 : (small_frac >> amt);
		lost_mask  = long_shift ? '1 : ((FRAC_W'(1) << amt) - FRAC_W'(1));
		sticky     = |(small_frac & lost_mask);
		aligned    = {shifted[FRAC_W-1:1], shifted[0] | sticky};
	end

endmodule

`default_nettype wire

// ===== rtl/core/fp32_add_operand_align.sv =====
// ---------------------------------------------------------------------------
// fp32_add_operand_align
// Front-end alignment of two single-precision operands for an adder.
// ---------------------------------------------------------------------------
// Takes one operand pair per clock while not stalled and returns one result
// word per pair, in order. Each word passes an input register (_s1) and a
// result register (_s2) before it shows on the output; throughput is one
// word per cycle when not stalled. The path between the two registers
// is the exponent subtract and the 28-bit alignment shifter with its sticky
// OR. Backpressure stalls both registers; the input side stays open while a
// finished word waits, as long as the s1 slot is free.
// Sign bits are ignored; exponent 255 is treated like any other exponent.
`default_nettype none

module fp32_add_operand_align (
	input  wire             clk,
	input  wire             arst_n,
	fpalign_in_if.sink      operands,
	fpalign_out_if.source   aligned
);
	import fpalign_pkg::*;
	`include "fp32_add_operand_align_macros.svh"

	logic     valid_s1, valid_s2, ready_s2;
	opnd_t    a_s1, b_s1;
	exp_t     exp_s2;
	frac_t    frac_a_s2, frac_b_s2;
	unpack_t  unp;
	frac_t    shifted_frac;

	// flow control
	assign ready_s2       = !valid_s2 || aligned.ready;
	assign operands.ready = !valid_s1 || ready_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (operands.ready) begin
			valid_s1 <= operands.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (operands.valid && operands.ready) begin
			a_s1 <= operands.operand_a;
			b_s1 <= operands.operand_b;
		end
	end

	// alignment logic
	fpalign_unpack u_unpack (
		.operand_a (a_s1),
		.operand_b (b_s1),
		.unp       (unp)
	);

	fpalign_shift u_shift (
		.small_frac (unp.small_frac),
		.shift_dist (unp.shift_dist),
		.aligned    (shifted_frac)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			exp_s2    <= unp.larger_exp;
			frac_a_s2 <= unp.a_big ? unp.big_frac : shifted_frac;
			frac_b_s2 <= unp.a_big ? shifted_frac : unp.big_frac;
		end
	end

	assign aligned.valid              = valid_s2;
	assign aligned.larger_exponent    = exp_s2;
	assign aligned.aligned_fraction_a = frac_a_s2;
	assign aligned.aligned_fraction_b = frac_b_s2;

	// checks
	`FPALIGN_ASSERT_NXT(a_advance, valid_s1 && ready_s2, valid_s2,
		"word in s1 did not reach s2")
	`FPALIGN_ASSERT_IMP(a_no_int_overflow, valid_s2,
		!frac_a_s2[FRAC_W-1] && !frac_b_s2[FRAC_W-1],
		"top integer bit set in aligned fraction")
	`FPALIGN_ASSERT_IMP(a_big_hidden, valid_s2 && (exp_s2 != '0),
		frac_a_s2[FRAC_W-2] || frac_b_s2[FRAC_W-2],
		"larger operand lost its hidden one")
	`FPALIGN_ASSERT_IMP(a_denorm_noshift, valid_s2 && (exp_s2 == '0),
		(frac_a_s2[2:0] == GUARD_ZERO) && (frac_b_s2[2:0] == GUARD_ZERO),
		"guard bits set with both operands denormal")

endmodule

`default_nettype wire
